>>> rtl/core/e2q_pkg.sv
// Shared constants, types and helpers for the Euler-to-quaternion core.
// Used by e2q_cordic_cell, e2q_quat_mult and euler_to_quaternion_core.
package e2q_pkg;

    localparam int ANGLE_WIDTH    = 16;
    localparam int QUAT_FRAC_BITS = 14;
    localparam int CORDIC_STAGES  = 16;

    localparam int NUM_ANGLES = 3;
    localparam int NUM_COMPS  = 4;

    // internal fixed point: 30 fraction bits everywhere
    localparam int INT_FRAC = 30;
    // angle field (AW-3 fraction bits) halved and moved to Q30
    localparam int ANGLE_SHIFT = INT_FRAC - 1 - (ANGLE_WIDTH - 3);

    localparam int XW    = 33;   // CORDIC x/y registers
    localparam int ZW    = 34;   // CORDIC angle accumulator
    localparam int CW    = 32;   // cos/sin and product terms
    localparam int SUMW  = CW + 1;
    localparam int QW    = QUAT_FRAC_BITS + 2;
    localparam int STG_W = 5;    // stage index, k = i mod 32

    localparam int IN_TDW  = ((NUM_ANGLES * ANGLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDW = ((NUM_COMPS * QW + 7) / 8) * 8;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    // data carried along the CORDIC chain; index 0 roll, 1 pitch, 2 yaw
    typedef struct packed {
        logic [NUM_ANGLES-1:0]          flip;
        logic [NUM_ANGLES-1:0][XW-1:0]  x;
        logic [NUM_ANGLES-1:0][XW-1:0]  y;
        logic [NUM_ANGLES-1:0][ZW-1:0]  z;
    } cord_t;

    typedef logic [NUM_COMPS-1:0][QW-1:0] quat_t;

    // Q30 product, round half toward +inf
    function automatic logic signed [CW-1:0] mul_q30(
        input logic signed [CW-1:0] a,
        input logic signed [CW-1:0] b
    );
        logic signed [2*CW-1:0] p;
        begin
            p = a * b;
            p = p + (64'sd1 <<< (INT_FRAC - 1));
            return p[INT_FRAC +: CW];
        end
    endfunction

endpackage

>>> rtl/core/e2q_cordic_cell.sv
// One CORDIC rotation step for all three half angles, with its own
// register and elastic valid/ready. Depends on e2q_pkg.
module e2q_cordic_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [e2q_pkg::STG_W-1:0] stage,
    input  logic                      up_valid,
    input  e2q_pkg::cord_t            up_data,
    output logic                      up_ready,
    output logic                      dn_valid,
    output e2q_pkg::cord_t            dn_data,
    input  logic                      dn_ready
);
    import e2q_pkg::*;

    logic  vld_reg;
    cord_t data_reg;
    cord_t data_next;

    always_comb
    begin
        logic signed [XW-1:0] xi;
        logic signed [XW-1:0] yi;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] zi;
        logic signed [ZW-1:0] at;
        data_next      = up_data;
        at = $signed({{(ZW-32){1'b0}}, ATAN_Q30[stage]});
        for (int j = 0; j < NUM_ANGLES; j++)
        begin
            xi = $signed(up_data.x[j]);
            yi = $signed(up_data.y[j]);
            zi = $signed(up_data.z[j]);
            dx = yi >>> stage;
            dy = xi >>> stage;
            if (!zi[ZW-1])
            begin
                data_next.x[j] = xi - dx;
                data_next.y[j] = yi + dy;
                data_next.z[j] = zi - at;
            end
            else
            begin
                data_next.x[j] = xi + dx;
                data_next.y[j] = yi - dy;
                data_next.z[j] = zi + at;
            end
        end
    end

    assign up_ready = ~vld_reg | dn_ready;
    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/core/e2q_quat_mult.sv
// Quaternion product sums: sign fix of cos/sin, pair products, triple
// products, then sum, round and clamp to +-1. Depends on e2q_pkg.
module e2q_quat_mult (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    input  e2q_pkg::cord_t up_data,
    output logic           up_ready,
    output logic           dn_valid,
    output e2q_pkg::quat_t dn_quat,
    input  logic           dn_ready
);
    import e2q_pkg::*;

    localparam int NST = 4;
    localparam int SH  = INT_FRAC - QUAT_FRAC_BITS;
    localparam logic signed [SUMW:0] RND = (SUMW+1)'((2 ** SH) / 2);
    localparam logic signed [SUMW:0] LIM = (SUMW+1)'(2 ** QUAT_FRAC_BITS);

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] rdy;

    // stage 0: cos/sin per angle
    logic signed [CW-1:0] c_reg [NUM_ANGLES];
    logic signed [CW-1:0] s_reg [NUM_ANGLES];
    // stage 1: pair products of roll and pitch, yaw terms carried
    logic signed [CW-1:0] pcc_reg, psc_reg, pcs_reg, pss_reg;
    logic signed [CW-1:0] cy_reg, sy_reg;
    // stage 2: two terms per component
    logic signed [CW-1:0] ta_reg [NUM_COMPS];
    logic signed [CW-1:0] tb_reg [NUM_COMPS];
    // stage 3: output
    quat_t q_reg;
    quat_t q_next;

    always_comb
    begin
        rdy[NST-1] = ~vld_reg[NST-1] | dn_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            rdy[i] = ~vld_reg[i] | rdy[i+1];
        end
    end

    assign up_ready = rdy[0];
    assign dn_valid = vld_reg[NST-1];
    assign dn_quat  = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= up_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [XW-1:0] xv;
        logic signed [XW-1:0] yv;
        if (up_valid && rdy[0])
        begin
            for (int j = 0; j < NUM_ANGLES; j++)
            begin
                xv = $signed(up_data.x[j]);
                yv = $signed(up_data.y[j]);
                if (up_data.flip[j])
                begin
                    xv = -xv;
                    yv = -yv;
                end
                c_reg[j] <= xv[CW-1:0];
                s_reg[j] <= yv[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[0] && rdy[1])
        begin
            pcc_reg <= mul_q30(c_reg[0], c_reg[1]);
            psc_reg <= mul_q30(s_reg[0], c_reg[1]);
            pcs_reg <= mul_q30(c_reg[0], s_reg[1]);
            pss_reg <= mul_q30(s_reg[0], s_reg[1]);
            cy_reg  <= c_reg[2];
            sy_reg  <= s_reg[2];
        end
    end

    // w = cc*cy + ss*sy   x = sc*cy - cs*sy
    // y = cs*cy + sc*sy   z = cc*sy - ss*cy
    always_ff @(posedge clk)
    begin
        if (vld_reg[1] && rdy[2])
        begin
            ta_reg[0] <= mul_q30(pcc_reg, cy_reg);
            tb_reg[0] <= mul_q30(pss_reg, sy_reg);
            ta_reg[1] <= mul_q30(psc_reg, cy_reg);
            tb_reg[1] <= -mul_q30(pcs_reg, sy_reg);
            ta_reg[2] <= mul_q30(pcs_reg, cy_reg);
            tb_reg[2] <= mul_q30(psc_reg, sy_reg);
            ta_reg[3] <= mul_q30(pcc_reg, sy_reg);
            tb_reg[3] <= -mul_q30(pss_reg, cy_reg);
        end
    end

    always_comb
    begin
        logic signed [SUMW:0] sum;
        logic signed [SUMW:0] v;
        for (int k = 0; k < NUM_COMPS; k++)
        begin
            sum = (SUMW+1)'(ta_reg[k]) + (SUMW+1)'(tb_reg[k]);
            v   = (sum + RND) >>> SH;
            if (v > LIM)
            begin
                v = LIM;
            end
            else if (v < -LIM)
            begin
                v = -LIM;
            end
            q_next[k] = v[QW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_reg[2] && rdy[3])
        begin
            q_reg <= q_next;
        end
    end

endmodule

>>> rtl/core/euler_to_quaternion_core.sv
// Euler angles (ZYX) to unit quaternion: half-angle range fold, a row of
// CORDIC cells and the product pipeline. Depends on e2q_pkg, e2q_cordic_cell,
// e2q_quat_mult.
//
//  port group   dir  contents
//  s_axis_*     in   roll, pitch, yaw angles
//  m_axis_*     out  quat_w, quat_x, quat_y, quat_z
//
// Fully pipelined: one transfer per cycle in and out while m_axis_tready
// is high. Stages: one fold stage, one CORDIC cell per iteration, four
// product/rounding stages.
// Every stage has its own valid bit and ready, so bubbles close up and
// input keeps flowing into empty stages while a finished result waits on m_axis_tready.
// Reset clears only the valid bits.
module euler_to_quaternion_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // roll, pitch, yaw (low to high), zero padded to bytes
    input  logic [e2q_pkg::IN_TDW-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z (low to high), zero padded to bytes
    output logic [e2q_pkg::OUT_TDW-1:0] m_axis_tdata
);
    import e2q_pkg::*;

    logic  fold_vld_reg;
    cord_t fold_reg;
    cord_t fold_next;
    logic  fold_ready;

    logic  chain_vld [CORDIC_STAGES+1];
    cord_t chain_dat [CORDIC_STAGES+1];
    logic  chain_rdy [CORDIC_STAGES+1];

    quat_t quat;

    // halve to Q30 and fold into +-pi/2
    always_comb
    begin
        logic signed [ANGLE_WIDTH-1:0] a;
        logic signed [ZW-1:0]          z;
        fold_next = '0;
        for (int j = 0; j < NUM_ANGLES; j++)
        begin
            a = $signed(s_axis_tdata[j*ANGLE_WIDTH +: ANGLE_WIDTH]);
            z = (ZW'(a)) <<< ANGLE_SHIFT;
            fold_next.flip[j] = 1'b0;
            if (z > HALF_PI_Q30)
            begin
                z = z - PI_Q30;
                fold_next.flip[j] = 1'b1;
            end
            else if (z < -HALF_PI_Q30)
            begin
                z = z + PI_Q30;
                fold_next.flip[j] = 1'b1;
            end
            fold_next.x[j] = GAIN_Q30;
            fold_next.y[j] = '0;
            fold_next.z[j] = z;
        end
    end

    assign fold_ready    = ~fold_vld_reg | chain_rdy[0];
    assign s_axis_tready = fold_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_vld_reg <= 1'b0;
        end
        else if (fold_ready)
        begin
            fold_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && fold_ready)
        begin
            fold_reg <= fold_next;
        end
    end

    assign chain_vld[0] = fold_vld_reg;
    assign chain_dat[0] = fold_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        e2q_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .stage    (STG_W'(i)),
            .up_valid (chain_vld[i]),
            .up_data  (chain_dat[i]),
            .up_ready (chain_rdy[i]),
            .dn_valid (chain_vld[i+1]),
            .dn_data  (chain_dat[i+1]),
            .dn_ready (chain_rdy[i+1])
        );
    end

    e2q_quat_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_vld[CORDIC_STAGES]),
        .up_data  (chain_dat[CORDIC_STAGES]),
        .up_ready (chain_rdy[CORDIC_STAGES]),
        .dn_valid (m_axis_tvalid),
        .dn_quat  (quat),
        .dn_ready (m_axis_tready)
    );

    assign m_axis_tdata = OUT_TDW'(quat);

endmodule
